/* rtl/core/skit_pkg.sv */
`default_nettype none
package skit_pkg;

    localparam int KEY_W            = 64;
    localparam int ELEM_OUT_W       = 6;
    localparam int COUNT_OUT_W      = 7;
    localparam int DEFAULT_CAPACITY = 64;

    typedef enum logic {
        OP_FIND = 1'b0,
        OP_ADD  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_DUPLICATE = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } state_t;

    typedef struct packed {
        op_t              operation;
        logic [KEY_W-1:0] key;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [ELEM_OUT_W-1:0]  element_index;
        logic [COUNT_OUT_W-1:0] entry_count;
    } result_t;

    // Controls broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic cmp_en;
        logic ins_en;
    } cell_ctrl_t;

endpackage
`default_nettype wire

/* rtl/core/skit_cell.sv */
`default_nettype none
module skit_cell #(
    parameter int CAPACITY = skit_pkg::DEFAULT_CAPACITY,
    parameter int INDEX    = 0,
    parameter int ELEM_W   = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                       clk,
    input  wire skit_pkg::cell_ctrl_t       ctrl,
    input  wire logic [skit_pkg::KEY_W-1:0] search_key,
    input  wire logic [ELEM_W-1:0]          new_elem,
    input  wire logic [CNT_W-1:0]           count,
    input  wire logic                       prev_lt,
    input  wire logic                       prev_ge,
    input  wire logic [skit_pkg::KEY_W-1:0] prev_key,
    input  wire logic [ELEM_W-1:0]          prev_elem,
    output logic                            lt,
    output logic                            ge,
    output logic                            eq,
    output logic [skit_pkg::KEY_W-1:0]      key,
    output logic [ELEM_W-1:0]               elem
);
    import skit_pkg::*;

    logic              occupied;
    logic              lt_reg;
    logic              ge_reg;
    logic              eq_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [ELEM_W-1:0] elem_reg;

    assign occupied = (CNT_W'(INDEX) < count);

    // Flags from the compare cycle; since the keys are sorted, the cells
    // holding smaller keys form a prefix of the row.
    always_ff @(posedge clk)
    begin
        if (ctrl.cmp_en)
        begin
            lt_reg <= occupied && (key_reg < search_key);
            ge_reg <= occupied && !(key_reg < search_key);
            eq_reg <= occupied && (key_reg == search_key);
        end
    end

    // The first cell not below the key takes the new key; every occupied
    // cell at or above it hands its contents one place up.
    always_ff @(posedge clk)
    begin
        if (ctrl.ins_en)
        begin
            if (prev_lt && !lt_reg)
            begin
                key_reg  <= search_key;
                elem_reg <= new_elem;
            end
            else if (prev_ge)
            begin
                key_reg  <= prev_key;
                elem_reg <= prev_elem;
            end
        end
    end

    assign lt   = lt_reg;
    assign ge   = ge_reg;
    assign eq   = eq_reg;
    assign key  = key_reg;
    assign elem = elem_reg;

endmodule
`default_nettype wire

/* rtl/core/sorted_key_index_table.sv */
`default_nettype none
// Sorted key table: an item is taken when start is high and busy is low. It
// passes through a compare step, where every cell checks its key against
// the item's key at once, and then an apply step, where the row reports the
// match and, for an add that is neither a duplicate nor into a full table,
// shifts the larger keys up one cell and inserts the new one. Busy is high
// only during the compare step, so a new item may be started in the apply
// step of the previous one. The result appears with done for exactly one
// cycle, the cycle after the apply step, and must be taken then: there is no
// way to hold it off. After reset the table is empty and ready at once.
module sorted_key_index_table #(
    parameter int CAPACITY = skit_pkg::DEFAULT_CAPACITY
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire skit_pkg::cmd_t    cmd,
    output logic                   busy,
    output logic                   done,
    output skit_pkg::result_t      result
);
    import skit_pkg::*;

    localparam int ELEM_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    state_t            state_reg;
    state_t            state_next;
    op_t               op_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              done_reg;
    logic              done_next;
    result_t           result_reg;
    result_t           result_next;

    logic              accept;
    cell_ctrl_t        ctrl;
    logic              present;
    logic              full;
    logic              do_insert;
    logic [ELEM_W-1:0] found_elem;

    logic              lt_vec   [CAPACITY];
    logic              ge_vec   [CAPACITY];
    logic              eq_vec   [CAPACITY];
    logic [KEY_W-1:0]  key_vec  [CAPACITY];
    logic [ELEM_W-1:0] elem_vec [CAPACITY];

    assign accept = start && !busy;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                skit_cell #(
                    .CAPACITY (CAPACITY),
                    .INDEX    (gi),
                    .ELEM_W   (ELEM_W),
                    .CNT_W    (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .search_key (key_reg),
                    .new_elem   (count_reg[ELEM_W-1:0]),
                    .count      (count_reg),
                    .prev_lt    (1'b1),
                    .prev_ge    (1'b0),
                    .prev_key   (key_reg),
                    .prev_elem  (count_reg[ELEM_W-1:0]),
                    .lt         (lt_vec[gi]),
                    .ge         (ge_vec[gi]),
                    .eq         (eq_vec[gi]),
                    .key        (key_vec[gi]),
                    .elem       (elem_vec[gi])
                );
            end
            else
            begin : g_rest
                skit_cell #(
                    .CAPACITY (CAPACITY),
                    .INDEX    (gi),
                    .ELEM_W   (ELEM_W),
                    .CNT_W    (CNT_W)
                ) u_cell (
                    .clk        (clk),
                    .ctrl       (ctrl),
                    .search_key (key_reg),
                    .new_elem   (count_reg[ELEM_W-1:0]),
                    .count      (count_reg),
                    .prev_lt    (lt_vec[gi-1]),
                    .prev_ge    (ge_vec[gi-1]),
                    .prev_key   (key_vec[gi-1]),
                    .prev_elem  (elem_vec[gi-1]),
                    .lt         (lt_vec[gi]),
                    .ge         (ge_vec[gi]),
                    .eq         (eq_vec[gi]),
                    .key        (key_vec[gi]),
                    .elem       (elem_vec[gi])
                );
            end
        end
    endgenerate

    // At most one cell matches, so an OR over the masked element numbers
    // picks out the match.
    always_comb
    begin
        present    = 1'b0;
        found_elem = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            present    = present | eq_vec[i];
            found_elem = found_elem | (elem_vec[i] & {ELEM_W{eq_vec[i]}});
        end
    end

    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign do_insert = (state_reg == S_APPLY) && (op_reg == OP_ADD) && !present && !full;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  state_next = accept ? S_CMP : S_IDLE;
            S_CMP:   state_next = S_APPLY;
            S_APPLY: state_next = accept ? S_CMP : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        busy        = (state_reg == S_CMP);
        ctrl.cmp_en = (state_reg == S_CMP);
        ctrl.ins_en = do_insert;
        count_next  = do_insert ? count_reg + 1'b1 : count_reg;
        done_next   = (state_reg == S_APPLY);

        result_next.element_index = '0;
        if (op_reg == OP_FIND)
        begin
            if (present)
            begin
                result_next.status        = ST_OK;
                result_next.element_index = ELEM_OUT_W'(found_elem);
            end
            else
            begin
                result_next.status = ST_NOT_FOUND;
            end
        end
        else if (present)
        begin
            result_next.status = ST_DUPLICATE;
        end
        else if (full)
        begin
            result_next.status = ST_FULL;
        end
        else
        begin
            result_next.status        = ST_OK;
            result_next.element_index = ELEM_OUT_W'(count_reg);
        end
        result_next.entry_count = COUNT_OUT_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.operation;
            key_reg <= cmd.key;
        end
        if (state_reg == S_APPLY)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
`default_nettype wire
